// ===== hw/rtl/multi_stream_timestamp_aligner_core_assert.svh =====
// Assertion macros for the timestamp aligner core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MULTI_STREAM_TIMESTAMP_ALIGNER_CORE_ASSERT_SVH
`define MULTI_STREAM_TIMESTAMP_ALIGNER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define MSTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MSTA_ASSERT_IMP(lbl, ante, cons)
`define MSTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/msta_pkg.sv =====
// Shared types and constants for the timestamp aligner.
// No dependencies.
`default_nettype none
package msta_pkg;

  localparam int STAMP_W    = 63;
  localparam int SUM_W      = STAMP_W + 1;
  localparam int PERIOD_W   = 40;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 2;
  localparam int SLOT_FIELDS = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam op_t     STREAM_DEPTH    = 2'd0;
  localparam slot_t   SLOT_NONE       = 2'd3;
  localparam period_t PERIOD_RESET    = 40'd200000000;
  // register index is paddr[CFG_ADDR_W-1] (8-byte registers)
  localparam logic    REG_EMIT_PERIOD = 1'b0;

  typedef struct packed {
    op_t    reference_stream;
    stamp_t reference_stamp;
    slot_t  depth_slot;
    slot_t  colour_slot;
    slot_t  ir_slot;
    slot_t  ir2_slot;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/msta_if.sv =====
// Handshake channels for frame events and aligned results.
// Depends on msta_pkg.
`default_nettype none
interface msta_in_if;
  logic               valid;
  logic               ready;
  msta_pkg::op_t      operation;
  msta_pkg::stamp_t   frame_stamp;
  modport source (output valid, operation, frame_stamp, input ready);
  modport sink   (input valid, operation, frame_stamp, output ready);
endinterface

interface msta_out_if;
  logic               valid;
  logic               ready;
  msta_pkg::op_t      reference_stream;
  msta_pkg::stamp_t   reference_stamp;
  msta_pkg::slot_t    depth_slot;
  msta_pkg::slot_t    colour_slot;
  msta_pkg::slot_t    ir_slot;
  msta_pkg::slot_t    ir2_slot;
  modport source (output valid, reference_stream, reference_stamp, depth_slot,
                  colour_slot, ir_slot, ir2_slot, input ready);
  modport sink   (input valid, reference_stream, reference_stamp, depth_slot,
                  colour_slot, ir_slot, ir2_slot, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/msta_front.sv =====
// Front end: accepts frame events, keeps per-stream stamp history and the
// emit timer, and queues a history snapshot for every emitting depth event.
// Depends on msta_pkg and msta_if.
`default_nettype none
module msta_front #(
  parameter int STREAM_COUNT  = 4,
  parameter int HISTORY_DEPTH = 3,
  parameter int HIST_W        = STREAM_COUNT * HISTORY_DEPTH * msta_pkg::STAMP_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  msta_in_if.sink              in_ch,
  input  msta_pkg::period_t    emit_period,
  output logic                 enq_valid,
  input  logic                 enq_ready,
  output logic [HIST_W-1:0]    enq_hist
);

  typedef msta_pkg::stamp_t [STREAM_COUNT-1:0][HISTORY_DEPTH-1:0] hist_t;

  hist_t                     hist_r, hist_nxt;
  msta_pkg::stamp_t          last_emit_r, last_emit_nxt;
  logic                      accept;
  logic                      emit;
  logic [msta_pkg::SUM_W-1:0] threshold;

  assign in_ch.ready = enq_ready;
  assign accept      = in_ch.valid && enq_ready;

  // ids at or above STREAM_COUNT match no stream and leave history alone
  always_comb begin
    hist_nxt = hist_r;
    if (accept) begin
      for (int s = 0; s < STREAM_COUNT; s++) begin
        if (32'(in_ch.operation) == s) begin
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            hist_nxt[s][k] = hist_r[s][k-1];
          end
          hist_nxt[s][0] = in_ch.frame_stamp;
        end
      end
    end
  end

  assign threshold = {1'b0, last_emit_r} +
                     {{(msta_pkg::SUM_W - msta_pkg::PERIOD_W){1'b0}}, emit_period};

  assign emit = accept && (in_ch.operation == msta_pkg::STREAM_DEPTH) &&
                ({1'b0, in_ch.frame_stamp} >= threshold);

  assign last_emit_nxt = emit ? in_ch.frame_stamp : last_emit_r;

  assign enq_valid = emit;
  assign enq_hist  = hist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      last_emit_r <= '0;
    end else begin
      hist_r      <= hist_nxt;
      last_emit_r <= last_emit_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/msta_queue.sv =====
// Short request queue between the front end and the matcher.
// Depends on msta_pkg (depth).
`default_nettype none
module msta_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int Depth  = msta_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = PtrW + 1;

  logic [WIDTH-1:0]  slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CountW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_q[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/msta_back.sv =====
// Back end: picks the reference stream from a history snapshot, finds the
// matching slot of every stream and holds the result for the sink.
// Depends on msta_pkg and msta_if.
`default_nettype none
module msta_back #(
  parameter int STREAM_COUNT  = 4,
  parameter int HISTORY_DEPTH = 3,
  parameter int HIST_W        = STREAM_COUNT * HISTORY_DEPTH * msta_pkg::STAMP_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              deq_valid,
  output logic              deq_ready,
  input  logic [HIST_W-1:0] deq_hist,
  msta_out_if.source        out_ch
);

  localparam int IdW = $clog2(STREAM_COUNT);

  typedef msta_pkg::stamp_t [STREAM_COUNT-1:0][HISTORY_DEPTH-1:0] hist_t;

  hist_t                                              hist;
  logic [STREAM_COUNT-1:0]                            win;
  logic [STREAM_COUNT-1:0][STREAM_COUNT-1:0][HISTORY_DEPTH-1:0] eq;
  logic [IdW-1:0]                                     ref_id;
  msta_pkg::stamp_t                                   ref_t;
  msta_pkg::slot_t [STREAM_COUNT-1:0]                 slot_all;
  msta_pkg::slot_t [msta_pkg::SLOT_FIELDS-1:0]        slot_field;
  logic                                               pop;
  logic                                               out_valid_r, out_valid_nxt;
  msta_pkg::result_t                                  res_r, res_nxt;

  assign hist = deq_hist;

  // a stream wins if strictly below every lower id and not above any higher id
  always_comb begin
    for (int s = 0; s < STREAM_COUNT; s++) begin
      win[s] = 1'b1;
      for (int j = 0; j < STREAM_COUNT; j++) begin
        if (j < s && !(hist[s][0] < hist[j][0])) win[s] = 1'b0;
        if (j > s && !(hist[s][0] <= hist[j][0])) win[s] = 1'b0;
      end
    end
  end

  // every candidate's newest stamp against every history entry, in parallel
  always_comb begin
    for (int s = 0; s < STREAM_COUNT; s++) begin
      for (int f = 0; f < STREAM_COUNT; f++) begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          eq[s][f][k] = (hist[s][0] == hist[f][k]);
        end
      end
    end
  end

  always_comb begin
    ref_id = '0;
    ref_t  = '0;
    for (int s = 0; s < STREAM_COUNT; s++) begin
      if (win[s]) begin
        ref_id = ref_id | IdW'(s);
        ref_t  = ref_t | hist[s][0];
      end
    end
  end

  // bit s: candidate s's newest stamp equals entry k of stream f
  function automatic logic [STREAM_COUNT-1:0] eq_col(input int f, input int k);
    logic [STREAM_COUNT-1:0] col;
    for (int s = 0; s < STREAM_COUNT; s++) begin
      col[s] = eq[s][f][k];
    end
    return col;
  endfunction

  // lowest matching slot wins; slots past the field range report none
  always_comb begin
    logic hit;
    for (int f = 0; f < STREAM_COUNT; f++) begin
      slot_all[f] = msta_pkg::SLOT_NONE;
      for (int k = HISTORY_DEPTH - 1; k >= 0; k--) begin
        hit = |(win & eq_col(f, k));
        if (hit) begin
          slot_all[f] = (k < int'(msta_pkg::SLOT_NONE)) ? msta_pkg::slot_t'(k)
                                                       : msta_pkg::SLOT_NONE;
        end
      end
    end
  end

  always_comb begin
    slot_field = {msta_pkg::SLOT_FIELDS{msta_pkg::SLOT_NONE}};
    for (int f = 0; f < STREAM_COUNT && f < msta_pkg::SLOT_FIELDS; f++) begin
      slot_field[f] = slot_all[f];
    end
  end

  assign deq_ready = !out_valid_r || out_ch.ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    res_nxt.reference_stream = msta_pkg::op_t'(ref_id);
    res_nxt.reference_stamp  = ref_t;
    res_nxt.depth_slot       = slot_field[0];
    res_nxt.colour_slot      = slot_field[1];
    res_nxt.ir_slot          = slot_field[2];
    res_nxt.ir2_slot         = slot_field[3];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.reference_stream = res_r.reference_stream;
  assign out_ch.reference_stamp  = res_r.reference_stamp;
  assign out_ch.depth_slot       = res_r.depth_slot;
  assign out_ch.colour_slot      = res_r.colour_slot;
  assign out_ch.ir_slot          = res_r.ir_slot;
  assign out_ch.ir2_slot         = res_r.ir2_slot;

endmodule
`default_nettype wire

// ===== hw/rtl/multi_stream_timestamp_aligner_core.sv =====
// Timestamp aligner top: APB register, front end, request queue, matcher.
// Throughput one frame event per cycle while the request queue has room; a full queue stalls every event.
// An emitting depth event's snapshot is registered in the request queue, then matched and held in the output register.
// Non-emitting events produce nothing and occupy no queue entry.
// Reset (synchronous, rst_n low): histories and last emit time zero, period 200000000 ns,
// queue and output empty; no clearing pass, the block is ready right after reset.
`default_nettype none
`include "multi_stream_timestamp_aligner_core_assert.svh"
module multi_stream_timestamp_aligner_core #(
  parameter int STREAM_COUNT  = 4,
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  msta_in_if.sink                            in_ch,
  msta_out_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [msta_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [msta_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [msta_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int HistW = STREAM_COUNT * HISTORY_DEPTH * msta_pkg::STAMP_W;

  msta_pkg::period_t period_r, period_nxt;
  logic              reg_idx;
  logic              cfg_write;
  logic              enq_valid, enq_ready;
  logic [HistW-1:0]  enq_hist;
  logic              deq_valid, deq_ready;
  logic [HistW-1:0]  deq_hist;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[msta_pkg::CFG_ADDR_W-1];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign period_nxt = (cfg_write && reg_idx == msta_pkg::REG_EMIT_PERIOD)
                      ? cfg_pwdata[msta_pkg::PERIOD_W-1:0] : period_r;

  assign cfg_prdata = (reg_idx == msta_pkg::REG_EMIT_PERIOD)
                      ? {{(msta_pkg::CFG_DATA_W - msta_pkg::PERIOD_W){1'b0}}, period_r}
                      : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= msta_pkg::PERIOD_RESET;
    end else begin
      period_r <= period_nxt;
    end
  end

  msta_front #(
    .STREAM_COUNT  (STREAM_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HIST_W        (HistW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .emit_period (period_r),
    .enq_valid   (enq_valid),
    .enq_ready   (enq_ready),
    .enq_hist    (enq_hist)
  );

  msta_queue #(
    .WIDTH (HistW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (enq_valid),
    .push_ready (enq_ready),
    .push_data  (enq_hist),
    .pop_valid  (deq_valid),
    .pop_ready  (deq_ready),
    .pop_data   (deq_hist)
  );

  msta_back #(
    .STREAM_COUNT  (STREAM_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HIST_W        (HistW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_hist  (deq_hist),
    .out_ch    (out_ch)
  );

  `MSTA_ASSERT_IMP(a_enq_has_room, enq_valid, enq_ready)
  `MSTA_ASSERT_IMP(a_only_depth_emits, enq_valid, in_ch.operation == msta_pkg::STREAM_DEPTH)
  `MSTA_ASSERT_IMP(a_no_pop_on_stall, out_ch.valid && !out_ch.ready, !deq_ready)
  `MSTA_ASSERT_NEXT(a_pop_fills_output, deq_valid && deq_ready, out_ch.valid)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for multi_stream_timestamp_aligner_core: directed and
// random frame events, period writes over APB, random and long stalls.
// Needs msta_pkg, the msta_in_if / msta_out_if channels and the core RTL.
module tb;
  import msta_pkg::*;

  localparam int HIST_DEPTH = 3;
  localparam int STREAMS = 4;
  localparam op_t STREAM_COLOUR = 2'd1;
  localparam op_t STREAM_IR = 2'd2;
  localparam op_t STREAM_IR2 = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_EMIT_PERIOD =
    {REG_EMIT_PERIOD, {(CFG_ADDR_W-1){1'b0}}};
  localparam stamp_t STAMP_MAX = '1;
  localparam period_t PERIOD_MAX = '1;
  localparam logic [63:0] BASE_PERIOD = 64'd200000000;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;

  msta_in_if in_bus ();
  msta_out_if out_bus ();
  assign out_bus.ready = sink_ready;

  // predictor state
  stamp_t frame_history [STREAMS][HIST_DEPTH];
  stamp_t last_emit;
  period_t emit_period;
  result_t sets_due [$];

  int errors = 0;
  int items_sent = 0;
  int sets_checked = 0;
  int period_settings = 0;
  int quiet_cycles = 0;
  int sink_hold = 0;
  int sink_gap = 0;
  bit traffic_gaps = 1'b1;
  logic [63:0] frame_clock = '0;

  multi_stream_timestamp_aligner_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic slot_t match_slot(int s, stamp_t st);
    slot_t slot;
    slot = SLOT_NONE;
    // scan oldest to newest so the newest match wins
    for (int k = HIST_DEPTH - 1; k >= 0; k--)
      if (frame_history[s][k] == st) slot = slot_t'(k);
    return slot;
  endfunction

  task automatic align_frame(input op_t op, input stamp_t st);
    result_t aligned;
    stamp_t ref_stamp;
    op_t ref_id;
    logic [63:0] due;
    for (int k = HIST_DEPTH - 1; k > 0; k--) frame_history[op][k] = frame_history[op][k-1];
    frame_history[op][0] = st;
    due = {1'b0, last_emit} + {24'b0, emit_period};
    if (op != STREAM_DEPTH || {1'b0, st} < due) return;
    ref_id = STREAM_DEPTH;
    ref_stamp = frame_history[STREAM_DEPTH][0];
    for (int s = 1; s < STREAMS; s++) begin
      if (frame_history[s][0] < ref_stamp) begin
        ref_stamp = frame_history[s][0];
        ref_id = op_t'(s);
      end
    end
    aligned.reference_stream = ref_id;
    aligned.reference_stamp = ref_stamp;
    aligned.depth_slot = match_slot(STREAM_DEPTH, ref_stamp);
    aligned.colour_slot = match_slot(STREAM_COLOUR, ref_stamp);
    aligned.ir_slot = match_slot(STREAM_IR, ref_stamp);
    aligned.ir2_slot = match_slot(STREAM_IR2, ref_stamp);
    sets_due.push_back(aligned);
    last_emit = st;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // predictor update and result check, all sampled at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (frame_history[s, k]) frame_history[s][k] = '0;
      last_emit = '0;
      emit_period = PERIOD_RESET;
      sets_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1] == REG_EMIT_PERIOD)
        emit_period = cfg_pwdata[PERIOD_W-1:0];
      if (in_bus.valid && in_bus.ready) align_frame(in_bus.operation, in_bus.frame_stamp);
      if (out_bus.valid && out_bus.ready) begin
        if (sets_due.size() == 0) begin
          $error("aligned set returned with no request pending");
          errors++;
        end else begin
          want = sets_due.pop_front();
          check_field("reference_stream", want.reference_stream, out_bus.reference_stream);
          check_field("reference_stamp", want.reference_stamp, out_bus.reference_stamp);
          check_field("depth_slot", want.depth_slot, out_bus.depth_slot);
          check_field("colour_slot", want.colour_slot, out_bus.colour_slot);
          check_field("ir_slot", want.ir_slot, out_bus.ir_slot);
          check_field("ir2_slot", want.ir2_slot, out_bus.ir2_slot);
          sets_checked++;
        end
      end
    end
  end

  // result receiver: long holds on request, otherwise short random bursts
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_gap > 0) begin
      sink_ready <= 1'b0;
      sink_gap = sink_gap - 1;
    end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
      sink_ready <= 1'b0;
      sink_gap = $urandom_range(0, 4);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        cfg_psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // one frame event; returns at the edge where the request is taken
  task automatic send_frame(input op_t op, input stamp_t st);
    int gap;
    gap = (traffic_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= op;
    in_bus.frame_stamp <= st;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and let every pending set drain before touching the register
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sets_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_period();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_EMIT_PERIOD;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("emit_period", {24'b0, emit_period}, cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_period(input logic [63:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_EMIT_PERIOD;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    period_settings++;
    read_period();
  endtask

  // reset period, one below and exactly at the emit threshold;
  // untouched histories still hold zero and match
  task automatic test_emit_threshold();
    read_period();
    send_frame(STREAM_DEPTH, stamp_t'(BASE_PERIOD - 1));
    send_frame(STREAM_DEPTH, stamp_t'(BASE_PERIOD));
  endtask

  task automatic test_tie_and_slots();
    // all newest stamps equal: lowest id wins
    send_frame(STREAM_COLOUR, stamp_t'(2 * BASE_PERIOD));
    send_frame(STREAM_IR, stamp_t'(2 * BASE_PERIOD));
    send_frame(STREAM_IR2, stamp_t'(2 * BASE_PERIOD));
    send_frame(STREAM_DEPTH, stamp_t'(2 * BASE_PERIOD));
    // colour is reference, ir2 matches one slot back
    send_frame(STREAM_IR2, stamp_t'(3 * BASE_PERIOD));
    send_frame(STREAM_COLOUR, stamp_t'(3 * BASE_PERIOD));
    send_frame(STREAM_IR, stamp_t'(3 * BASE_PERIOD + 7));
    send_frame(STREAM_IR2, stamp_t'(3 * BASE_PERIOD + 9));
    send_frame(STREAM_DEPTH, stamp_t'(4 * BASE_PERIOD));
  endtask

  task automatic test_stamp_extremes();
    send_frame(STREAM_IR, '0);
    send_frame(STREAM_COLOUR, STAMP_MAX);
    send_frame(STREAM_IR2, stamp_t'(64'h5555_5555_5555_5555));
    send_frame(STREAM_DEPTH, stamp_t'(5 * BASE_PERIOD));
  endtask

  // widest, narrowest and zero period, each probed at its threshold;
  // junk in the upper write bits must be dropped
  task automatic test_period_register();
    logic [63:0] base;
    settle();
    base = last_emit;
    program_period('1);
    send_frame(STREAM_DEPTH, stamp_t'(base + PERIOD_MAX - 1));
    send_frame(STREAM_DEPTH, stamp_t'(base + PERIOD_MAX));
    base = base + PERIOD_MAX;
    settle();
    program_period({24'hA5A5A5, 40'd1});
    send_frame(STREAM_DEPTH, stamp_t'(base + 1));
    send_frame(STREAM_DEPTH, stamp_t'(base + 1));
    base = base + 1;
    settle();
    program_period(64'd0);
    send_frame(STREAM_DEPTH, stamp_t'(base));
    send_frame(STREAM_DEPTH, stamp_t'(base - 1));
  endtask

  // frame sets sharing one stamp, in random stream order, with dropped
  // frames, jittered stamps and stray events mixed in
  task automatic run_random_phase(input logic [63:0] period_word, input int n_items,
                                  input bit gaps);
    logic [63:0] per;
    op_t order [STREAMS];
    op_t tmp;
    int j, pick, first;
    settle();
    program_period(period_word);
    per = {24'b0, emit_period};
    if (frame_clock < {1'b0, last_emit}) frame_clock = {1'b0, last_emit};
    traffic_gaps = gaps;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 9) == 0) traffic_gaps = gaps && ($urandom_range(0, 2) != 0);
      frame_clock = (frame_clock + (per >> 1) + rand64() % (per + 2)) & {1'b0, STAMP_MAX};
      if ($urandom_range(0, 9) == 0) begin
        tmp = op_t'($urandom_range(0, 3));
        if (tmp == STREAM_DEPTH) send_frame(tmp, stamp_t'(rand64() % (frame_clock + 1)));
        else send_frame(tmp, stamp_t'(rand64()));
      end
      for (int i = 0; i < STREAMS; i++) order[i] = op_t'(i);
      for (int i = STREAMS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      foreach (order[i]) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) continue;
        if (pick == 1 && frame_clock > 16)
          send_frame(order[i], stamp_t'(frame_clock - $urandom_range(1, 16)));
        else
          send_frame(order[i], stamp_t'(frame_clock));
      end
    end
  endtask

  // receiver holds off while every depth request emits, so the core backs up
  task automatic test_backpressure();
    logic [63:0] base;
    settle();
    program_period(64'd1);
    base = last_emit;
    traffic_gaps = 1'b0;
    @(posedge clk);
    sink_hold = HOLD_CYCLES;
    for (int i = 1; i <= 12; i++) send_frame(STREAM_DEPTH, stamp_t'(base + i));
    settle();
    traffic_gaps = 1'b1;
    for (int i = 13; i <= 20; i++) send_frame(op_t'(i % STREAMS), stamp_t'(base + i));
  endtask

  // top of the stamp range; with the widest period nothing can emit after it
  task automatic test_stamp_ceiling();
    settle();
    traffic_gaps = 1'b0;
    program_period(64'd0);
    send_frame(STREAM_IR2, STAMP_MAX);
    send_frame(STREAM_IR, STAMP_MAX);
    send_frame(STREAM_COLOUR, STAMP_MAX);
    send_frame(STREAM_DEPTH, STAMP_MAX);
    send_frame(STREAM_DEPTH, STAMP_MAX);
    settle();
    program_period('1);
    send_frame(STREAM_DEPTH, STAMP_MAX);
    send_frame(STREAM_DEPTH, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = STREAM_DEPTH;
    in_bus.frame_stamp = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_EMIT_PERIOD;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_emit_threshold();
    test_tie_and_slots();
    test_stamp_extremes();
    test_period_register();
    run_random_phase(BASE_PERIOD, 110, 1'b1);
    run_random_phase(64'd1, 110, 1'b1);
    run_random_phase('1, 110, 1'b1);
    run_random_phase(rand64(), 110, 1'b1);
    run_random_phase(64'($urandom_range(2, 1000)), 110, 1'b1);
    run_random_phase(64'd0, 110, 1'b1);
    test_backpressure();
    run_random_phase(64'($urandom_range(1000, 400000000)), 110, 1'b0);
    test_stamp_ceiling();
    settle();

    $display("%0d frame events, %0d aligned sets checked, %0d period writes",
             items_sent, sets_checked, period_settings);
    $display("ties, slot matches, threshold edges, stamp extremes and stalls exercised");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/msta_pkg.sv
hw/rtl/msta_if.sv
hw/rtl/msta_front.sv
hw/rtl/msta_queue.sv
hw/rtl/msta_back.sv
hw/rtl/multi_stream_timestamp_aligner_core.sv
tb/tb.sv
